@@ hw/rtl/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`define ASSERT_SAME(label, clk, rst, ante, cons)
`endif
`endif

@@ hw/rtl/tccs_pkg.sv @@
// ----------------------------------------------------------------------------
// tccs_pkg
// Geometry, field widths, codes and the controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package tccs_pkg;

   localparam int COLUMNS    = 80;
   localparam int ROWS       = 25;
   localparam int CELL_COUNT = COLUMNS * ROWS;

   localparam int ADDR_W     = $clog2(CELL_COUNT);
   localparam int ROW_W      = $clog2(ROWS);
   localparam int ROW_SUM_W  = ROW_W + 1;
   // Holds a tab target, which may reach COLUMNS + 7 before the line wraps.
   localparam int COL_W      = $clog2(COLUMNS + 8);

   localparam int ACTION_W   = 2;
   localparam int CHAR_W     = 8;
   localparam int RROW_W     = 5;
   localparam int RCOL_W     = 7;
   localparam int POS_W      = 11;
   localparam int CELL_W     = 16;
   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 32;

   localparam logic [7:0] BLANK_CHAR = 8'h20;
   localparam logic [7:0] RESET_ATTR = 8'h07;

   localparam logic [ACTION_W-1:0] ACT_PUT  = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_READ = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_INIT = 2'd2;

   localparam logic [CHAR_W-1:0] CH_BS  = 8'd8;
   localparam logic [CHAR_W-1:0] CH_TAB = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF  = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR  = 8'd13;

   typedef struct packed {
      logic capture;
      logic exec;
      logic sweep_step;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic exec_sweep;
      logic sweep_done;
      logic out_free;
   } sts_type;

endpackage

`default_nettype wire

@@ hw/rtl/tccs_ctrl.sv @@
// ----------------------------------------------------------------------------
// tccs_ctrl
// Sequencer for the console: clearing pass, request execution, screen
// sweeps and result hand-off.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_ctrl import tccs_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_tvalid,
   output logic         req_tready,
   output cmd_type      cmd,
   input  wire sts_type sts
);

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_EXEC  = 6'b000100,
      ST_SWEEP = 6'b001000,
      ST_DONE  = 6'b010000,
      ST_SPARE = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (sts.sweep_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in = sts.exec_sweep ? ST_SWEEP : ST_DONE;
         end
         ST_SWEEP: begin
            if (sts.sweep_done) state_in = ST_DONE;
         end
         ST_DONE: begin
            if (sts.out_free) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready     = (state_ff == ST_IDLE);
   assign cmd.capture    = (state_ff == ST_IDLE) && req_tvalid;
   assign cmd.exec       = (state_ff == ST_EXEC);
   assign cmd.sweep_step = (state_ff == ST_CLEAR) || (state_ff == ST_SWEEP);
   assign cmd.load_out   = (state_ff == ST_DONE) && sts.out_free;

endmodule

`default_nettype wire

@@ hw/rtl/tccs_datapath.sv @@
// ----------------------------------------------------------------------------
// tccs_datapath
// Screen memory, cursor and scroll registers, sweep counter and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module tccs_datapath import tccs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic [ACTION_W-1:0]   req_action,
   input  wire logic [CHAR_W-1:0]     req_char,
   input  wire logic [RROW_W-1:0]     req_row,
   input  wire logic [RCOL_W-1:0]     req_col,
   input  wire logic                  csr_wr_en,
   input  wire logic [7:0]            csr_wr_data,
   input  wire cmd_type               cmd,
   output sts_type                    sts,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0]      rsp_tdata
);

   logic [CELL_W-1:0] mem [CELL_COUNT];

   logic [ACTION_W-1:0] act_ff;
   logic [CHAR_W-1:0]   char_ff;
   logic [RROW_W-1:0]   rrow_ff;
   logic [RCOL_W-1:0]   rcol_ff;

   logic [ROW_W-1:0]    row_ff, row_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [ROW_W-1:0]    top_ff, top_in;
   logic                en_ff, en_in;
   logic [7:0]          attr_ff;

   logic [ADDR_W-1:0]   sweep_addr_ff, sweep_last_ff;
   logic [CELL_W-1:0]   sweep_data_ff;

   logic [CELL_W-1:0]   rd_data_ff;
   logic                read_hit_ff;
   logic                rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;

   logic                is_put, is_read, is_init, rd_ok;
   logic                wr_cell, new_line, scroll;
   logic [COL_W-1:0]    col_plus1, tab_sum, tab_col, wr_col;
   logic [CELL_W-1:0]   wr_data, blank;
   logic [ROW_SUM_W-1:0] cur_sum, rd_sum;
   logic [ROW_W-1:0]    cur_phys, rd_phys, rd_row, top_plus1;
   logic [ADDR_W-1:0]   wr_addr, rd_addr, scroll_base, cur_pos;

   assign blank   = {attr_ff, BLANK_CHAR};
   assign is_put  = (act_ff == ACT_PUT) && en_ff;
   assign is_read = (act_ff == ACT_READ);
   assign is_init = (act_ff == ACT_INIT);
   assign rd_ok   = is_read && (32'(rrow_ff) < ROWS) && (32'(rcol_ff) < COLUMNS);

   assign col_plus1 = col_ff + COL_W'(1);
   assign tab_sum   = col_ff + COL_W'(8);
   assign tab_col   = {tab_sum[COL_W-1:3], 3'b000};
   assign top_plus1 = (top_ff == ROW_W'(ROWS - 1)) ? '0 : top_ff + ROW_W'(1);

   // Cursor update for one character, control codes included.
   always_comb begin
      wr_cell  = 1'b0;
      wr_col   = col_ff;
      wr_data  = {attr_ff, char_ff};
      new_line = 1'b0;
      col_in   = col_ff;
      case (char_ff)
         CH_LF: begin
            new_line = 1'b1;
         end
         CH_CR: begin
            col_in = '0;
         end
         CH_BS: begin
            if (col_ff != '0) begin
               col_in  = col_ff - COL_W'(1);
               wr_col  = col_ff - COL_W'(1);
               wr_cell = 1'b1;
               wr_data = blank;
            end
         end
         CH_TAB: begin
            if (32'(tab_col) >= COLUMNS) new_line = 1'b1;
            else col_in = tab_col;
         end
         default: begin
            wr_cell = 1'b1;
            if (32'(col_plus1) >= COLUMNS) new_line = 1'b1;
            else col_in = col_plus1;
         end
      endcase
      scroll = new_line && (row_ff == ROW_W'(ROWS - 1));
      row_in = row_ff;
      top_in = top_ff;
      en_in  = en_ff;
      if (new_line) begin
         col_in = '0;
         if (scroll) top_in = top_plus1;
         else row_in = row_ff + ROW_W'(1);
      end
      if (is_init) begin
         row_in = '0;
         col_in = '0;
         top_in = '0;
         en_in  = 1'b1;
      end else if (!is_put) begin
         row_in = row_ff;
         col_in = col_ff;
         top_in = top_ff;
      end
   end

   // The screen is a ring of rows: top_ff is the physical row shown first.
   assign cur_sum  = {1'b0, row_ff} + {1'b0, top_ff};
   assign cur_phys = (cur_sum >= ROW_SUM_W'(ROWS)) ? ROW_W'(cur_sum - ROW_SUM_W'(ROWS))
                                                   : ROW_W'(cur_sum);
   assign rd_row   = ROW_W'(rrow_ff);
   assign rd_sum   = {1'b0, rd_row} + {1'b0, top_ff};
   assign rd_phys  = (rd_sum >= ROW_SUM_W'(ROWS)) ? ROW_W'(rd_sum - ROW_SUM_W'(ROWS))
                                                  : ROW_W'(rd_sum);

   assign wr_addr     = ADDR_W'(cur_phys) * ADDR_W'(COLUMNS) + ADDR_W'(wr_col);
   assign rd_addr     = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(rcol_ff);
   assign scroll_base = ADDR_W'(top_ff) * ADDR_W'(COLUMNS);
   assign cur_pos     = ADDR_W'(row_ff) * ADDR_W'(COLUMNS) + ADDR_W'(col_ff);

   assign sts.exec_sweep = is_init || (is_put && scroll);
   assign sts.sweep_done = (sweep_addr_ff == sweep_last_ff);
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (cmd.sweep_step) begin
         mem[sweep_addr_ff] <= sweep_data_ff;
      end else if (cmd.exec && is_put && wr_cell) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.exec && rd_ok) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_action;
         char_ff <= req_char;
         rrow_ff <= req_row;
         rcol_ff <= req_col;
      end
      if (cmd.load_out) begin
         rsp_data_ff <= {4'b0000,
                         read_hit_ff ? rd_data_ff : {CELL_W{1'b0}},
                         en_ff,
                         POS_W'(cur_pos)};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff        <= '0;
         col_ff        <= '0;
         top_ff        <= '0;
         en_ff         <= 1'b0;
         attr_ff       <= RESET_ATTR;
         sweep_addr_ff <= '0;
         sweep_last_ff <= ADDR_W'(CELL_COUNT - 1);
         sweep_data_ff <= {RESET_ATTR, BLANK_CHAR};
         read_hit_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) attr_ff <= csr_wr_data;
         if (cmd.exec) begin
            row_ff      <= row_in;
            col_ff      <= col_in;
            top_ff      <= top_in;
            en_ff       <= en_in;
            read_hit_ff <= rd_ok;
            if (is_init) begin
               sweep_addr_ff <= '0;
               sweep_last_ff <= ADDR_W'(CELL_COUNT - 1);
               sweep_data_ff <= blank;
            end else if (is_put && scroll) begin
               // The old top row becomes the new bottom row and is blanked.
               sweep_addr_ff <= scroll_base;
               sweep_last_ff <= scroll_base + ADDR_W'(COLUMNS - 1);
               sweep_data_ff <= blank;
            end
         end else if (cmd.sweep_step && !sts.sweep_done) begin
            sweep_addr_ff <= sweep_addr_ff + ADDR_W'(1);
         end
         if (cmd.load_out) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

@@ hw/rtl/text_console_cursor_scroll_core.sv @@
// ----------------------------------------------------------------------------
// text_console_cursor_scroll_core
// Text-mode console: character output with cursor, scrolling and cell reads.
// Usage:
//   A request on req_* carries an action in req_tuser (put character, read
//   cell or init) and the character and read coordinates in req_tdata. Each
//   request gives exactly one response on rsp_*: the cursor position, the
//   enable flag and, for a read, the cell contents.
//   A put, a read or a line feed without scroll runs from acceptance through
//   the execute and done states into the output register. A scroll adds a
//   sweep to blank the new bottom row; the rows themselves are not moved, a
//   top-row pointer rotates. An init adds a blanking sweep over all
//   ROWS*COLUMNS cells (2000) through the single write port of the screen
//   memory. One request is in work at a time; the next is accepted once the
//   last response is loaded. After reset the block runs a clearing pass over
//   the screen memory with req_tready low; csr writes are taken during it.
//   The response sits in an output register; a stalled receiver holds the
//   block in its last step, and the next request is accepted once it drains.
//   csr_wr_data sets the attribute byte; write it only while idle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module text_console_cursor_scroll_core import tccs_pkg::*; (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   // [7:0] char_code, [12:8] read_row, [19:13] read_col, [23:20] zero
   input  wire logic [REQ_DATA_W-1:0] req_tdata,
   // [1:0] action
   input  wire logic [ACTION_W-1:0]   req_tuser,
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   // [10:0] cursor_pos, [11] enabled, [19:12] cell_char, [27:20] cell_attr,
   // [31:28] zero
   output logic [RSP_DATA_W-1:0]      rsp_tdata,
   input  wire logic                  csr_wr_en,
   input  wire logic [7:0]            csr_wr_data
);

   cmd_type cmd;
   sts_type sts;

   tccs_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   tccs_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_action  (req_tuser),
      .req_char    (req_tdata[7:0]),
      .req_row     (req_tdata[12:8]),
      .req_col     (req_tdata[19:13]),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .sts         (sts),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   // Only one request is in work at a time.
   `ASSERT_NEXT(a_one_in_work, clock, reset, req_tvalid && req_tready, !req_tready)
   // The result register is never loaded over a response that is still held.
   `ASSERT_SAME(a_load_free, clock, reset, cmd.load_out, sts.out_free)
   // Memory sweeps and request execution never share the write port.
   `ASSERT_SAME(a_port_excl, clock, reset, cmd.exec, !cmd.sweep_step)

endmodule

`default_nettype wire
